FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int CFG_W   = 17;

    localparam logic OP_PROBE  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    localparam logic [SCORE_W-1:0] MATE_BOUND    = 32'd32256;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = 32'h7FFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_NEG_MAX = 32'h8000_0001;
    localparam logic [7:0]         CLOCK_LIMIT   = 8'd60;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 17'h1_0000;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [7:0]         depth;
        logic [7:0]         flags;
        logic [15:0]        move;
    } t_entry;

    // The most negative score negates to itself, which still reads as above the bound.
    function automatic logic is_mate(input logic [SCORE_W-1:0] s);
        logic [SCORE_W-1:0] mag;
        mag = s[SCORE_W-1] ? (~s + 32'd1) : s;
        return mag > MATE_BOUND;
    endfunction

    // Stored mate scores are pulled toward zero by ply when read back.
    function automatic logic [SCORE_W-1:0] probe_adjust(input logic [SCORE_W-1:0] s,
                                                        input logic [6:0] ply);
        logic [SCORE_W-1:0] p;
        p = {25'd0, ply};
        if (!is_mate(s)) begin
            return s;
        end
        return s[SCORE_W-1] ? (s + p) : (s - p);
    endfunction

    // Mate scores are pushed away from zero by ply before they are stored.
    function automatic logic [SCORE_W-1:0] record_adjust(input logic [SCORE_W-1:0] s,
                                                         input logic [6:0] ply);
        logic [SCORE_W-1:0] p;
        p = {25'd0, ply};
        if (!is_mate(s)) begin
            return s;
        end
        return s[SCORE_W-1] ? (s - p) : (s + p);
    endfunction

endpackage

FILE: rtl/search_transposition_table_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Beat
// ---------+-----------+-------------------------+----------------------------------------
// input    | in        | i_in_valid / o_in_stall | op, hash, ply, depth, score, flags, ...
// output   | out       | o_out_valid/i_out_stall | hit, stored, entry score/depth/flags/move
// config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_data = slots in use
//
// Each input beat runs from acceptance to the result register through a one-bit-per-cycle
// restoring remainder of the 64-bit hash by the slot count, a memory access state and a state
// that forms the result once the output register is free; the next beat is taken only in idle.
// After reset the table memory is zeroed, one slot per cycle, across all TABLE_SLOTS slots;
// input beats are stalled meanwhile, configuration writes are taken at any time.
// A stalled result waits in the output register while the next beat is already taken.
module search_transposition_table_unit #(
    parameter int TABLE_SLOTS = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [stt_pkg::CFG_W-1:0]    i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [63:0]                  i_position_hash,
    input  logic [6:0]                   i_ply,
    input  logic signed [7:0]            i_search_depth,
    input  logic signed [31:0]           i_score,
    input  logic [7:0]                   i_bound_flags,
    input  logic [15:0]                  i_best_move,
    input  logic [7:0]                   i_halfmove_clock,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic                         o_stored,
    output logic signed [31:0]           o_entry_score,
    output logic signed [7:0]            o_entry_depth,
    output logic [7:0]                   o_entry_flags,
    output logic [15:0]                  o_entry_move
);
    import stt_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int DW    = IDX_W + 1;
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ACCESS = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    t_entry mem [TABLE_SLOTS];

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr_idx;
    logic [5:0]       r_bit_cnt;
    logic [63:0]      r_shift;
    logic [IDX_W-1:0] r_rem;
    logic [CFG_W-1:0] r_slots_cfg;

    logic             r_op;
    logic [63:0]      r_hash;
    logic [6:0]       r_ply;
    logic [7:0]       r_depth;
    logic [31:0]      r_score;
    logic [7:0]       r_flags;
    logic [15:0]      r_move;
    logic [7:0]       r_clock;

    t_entry           r_rd;

    logic             r_out_valid;
    logic             r_hit;
    logic             r_stored;
    logic [31:0]      r_out_score;
    logic [7:0]       r_out_depth;
    logic [7:0]       r_out_flags;
    logic [15:0]      r_out_move;

    logic [CW-1:0]    w_cfg_ext;
    logic [CW-1:0]    w_active_wide;
    logic [DW-1:0]    w_active;
    logic [DW-1:0]    w_trial;
    logic [IDX_W-1:0] w_rem_next;
    logic             w_in_accept;
    logic             w_skip;
    logic             w_out_free;
    logic             w_load;
    logic             w_we;
    logic [IDX_W-1:0] w_widx;
    t_entry           w_wdata;
    logic             w_probe_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // A slot count of zero acts as one; anything above the table depth saturates.
    assign w_cfg_ext = CW'(r_slots_cfg);
    always_comb begin
        if (r_slots_cfg == '0) begin
            w_active_wide = CW'(1);
        end else if (w_cfg_ext > CW'(TABLE_SLOTS)) begin
            w_active_wide = CW'(TABLE_SLOTS);
        end else begin
            w_active_wide = w_cfg_ext;
        end
    end
    assign w_active = DW'(w_active_wide[CNT_W-1:0]);

    // One restoring step: the remainder stays below the slot count.
    assign w_trial    = {r_rem, r_shift[63]};
    assign w_rem_next = (w_trial >= w_active) ? IDX_W'(w_trial - w_active)
                                              : w_trial[IDX_W-1:0];

    assign w_skip = (r_score == SCORE_MAX) || (r_score == SCORE_NEG_MAX) ||
                    (r_clock > CLOCK_LIMIT);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_RESULT) && w_out_free;

    always_comb begin
        w_we    = 1'b0;
        w_widx  = r_rem;
        w_wdata = '{key: r_hash, score: record_adjust(r_score, r_ply), depth: r_depth,
                    flags: r_flags, move: r_move};
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_widx  = r_clr_idx;
            w_wdata = '0;
        end else if (r_state == S_ACCESS && r_op == OP_RECORD && !w_skip) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_widx] <= w_wdata;
        end
        if (r_state == S_ACCESS) begin
            r_rd <= mem[r_rem];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IDX_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit_cnt == 6'd63) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_bit_cnt   <= '0;
            r_slots_cfg <= SLOTS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (r_state == S_DIV) begin
                r_bit_cnt <= r_bit_cnt + 6'd1;
            end else begin
                r_bit_cnt <= '0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_slots_cfg <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op    <= i_op;
            r_hash  <= i_position_hash;
            r_shift <= i_position_hash;
            r_rem   <= '0;
            r_ply   <= i_ply;
            r_depth <= i_search_depth;
            r_score <= i_score;
            r_flags <= i_bound_flags;
            r_move  <= i_best_move;
            r_clock <= i_halfmove_clock;
        end else if (r_state == S_DIV) begin
            r_shift <= {r_shift[62:0], 1'b0};
            r_rem   <= w_rem_next;
        end
    end

    assign w_probe_hit = (r_op == OP_PROBE) && (r_rd.key == r_hash);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hit       <= w_probe_hit;
            r_stored    <= (r_op == OP_RECORD) && !w_skip;
            r_out_score <= w_probe_hit ? probe_adjust(r_rd.score, r_ply) : '0;
            r_out_depth <= w_probe_hit ? r_rd.depth : '0;
            r_out_flags <= w_probe_hit ? r_rd.flags : '0;
            r_out_move  <= w_probe_hit ? r_rd.move  : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_stored      = r_stored;
    assign o_entry_score = r_out_score;
    assign o_entry_depth = r_out_depth;
    assign o_entry_flags = r_out_flags;
    assign o_entry_move  = r_out_move;

endmodule

FILE: rtl/stt_checker.sv
`timescale 1ns / 1ps

module stt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [stt_pkg::CFG_W-1:0] i_cfg_data,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_op,
    input logic [63:0]               i_position_hash,
    input logic [6:0]                i_ply,
    input logic signed [7:0]         i_search_depth,
    input logic signed [31:0]        i_score,
    input logic [7:0]                i_bound_flags,
    input logic [15:0]               i_best_move,
    input logic [7:0]                i_halfmove_clock,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_hit,
    input logic                      o_stored,
    input logic signed [31:0]        o_entry_score,
    input logic signed [7:0]         o_entry_depth,
    input logic [7:0]                o_entry_flags,
    input logic [15:0]               o_entry_move
);
    import stt_pkg::*;

    // A result beat held under stall keeps its hit, stored, score and move fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) &&
        $stable(o_stored) && $stable(o_entry_score) && $stable(o_entry_move))
        else $error("result beat changed while stalled");

    // A beat is either a probe hit or a stored record, never both.
    a_hit_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_stored))
        else $error("hit and stored both set");

    // Without a hit every entry field reads zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_entry_score == 32'sd0 && o_entry_depth == 8'sd0 &&
        o_entry_flags == 8'd0 && o_entry_move == 16'd0)
        else $error("entry fields nonzero without a hit");

    // The table is being cleared right after reset, so no beat may be taken.
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input taken during clearing pass");

    // One beat is worked at a time: acceptance of a record beat is followed by a stall.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_RECORD |=> o_in_stall)
        else $error("second beat taken while busy");

endmodule

bind search_transposition_table_unit stt_checker u_stt_checker (.*);
